// ===== hdl/bstf_pkg.sv =====
package bstf_pkg;

   // Time units of the two flash timers
   localparam int STROBE_UNIT_MS = 10;
   localparam int FLASH_UNIT_MS  = 100;

   // Widths of the timers and of the register port
   localparam int STROBE_TIMER_W = 12;
   localparam int FLASH_TIMER_W  = 16;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STROBE_FLASHES     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STROBE_HALF_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_ON_DUTY      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BRAKE_OFF_DUTY     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_ON_INTERVAL   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_OFF_INTERVAL  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_ON_DUTY       = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURN_OFF_DUTY      = 3'd7;

   // Register file contents as seen by the datapath
   typedef struct packed {
      logic [7:0] strobe_flashes;
      logic [7:0] strobe_half_period;
      logic [6:0] brake_on_duty;
      logic [6:0] brake_off_duty;
      logic [7:0] turn_on_interval;
      logic [7:0] turn_off_interval;
      logic [6:0] turn_on_duty;
      logic [6:0] turn_off_duty;
   } cfg_type;

endpackage

// ===== hdl/brake_strobe_turn_flasher_unit.sv =====
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  elapsed_ms, brake/left/right/hazard request
// rsp      out        rsp_valid/rsp_stall  brake/left/right duty, left/right lit
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One tick per cycle while the result is not stalled: a word sits in the
// input register, then the timers step and the result register loads.
// Reset clears the register file, timers, phases and valid flags.
// A stalled result holds the result register and the input register behind it;
// the input side is stalled only while the input register is full and cannot move.
module brake_strobe_turn_flasher_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_elapsed_ms,
   input  logic                              req_brake_request,
   input  logic                              req_left_request,
   input  logic                              req_right_request,
   input  logic                              req_hazard_request,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [6:0]                        rsp_brake_duty,
   output logic [6:0]                        rsp_left_duty,
   output logic [6:0]                        rsp_right_duty,
   output logic                              rsp_left_lit,
   output logic                              rsp_right_lit,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bstf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bstf_pkg::CSR_DATA_W-1:0]   csr_data
);

   bstf_pkg::cfg_type cfg;

   logic       in_valid_ff;
   logic [7:0] elapsed_ff;
   logic       brake_ff;
   logic       left_ff;
   logic       right_ff;
   logic       hazard_ff;

   logic       out_valid_ff;
   logic [6:0] brake_duty_ff;
   logic [6:0] left_duty_ff;
   logic [6:0] right_duty_ff;
   logic       left_lit_ff;
   logic       right_lit_ff;

   logic       advance;
   logic       step_en;
   logic       brake_lit_in;
   logic       dark_phase_in;
   logic       left_lit_in;
   logic       right_lit_in;

   // Move a word forward when the result register is free or draining
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step_en   = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;

   bstf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bstf_strobe u_strobe (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .step_en       (step_en),
      .elapsed_ms    (elapsed_ff),
      .brake_request (brake_ff),
      .brake_lit_in  (brake_lit_in)
   );

   bstf_flasher u_flasher (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .step_en       (step_en),
      .elapsed_ms    (elapsed_ff),
      .any_request   (left_ff || right_ff || hazard_ff),
      .dark_phase_in (dark_phase_in)
   );

   // Lamp phase per side
   assign left_lit_in  = !dark_phase_in && (left_ff || hazard_ff);
   assign right_lit_in = !dark_phase_in && (right_ff || hazard_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         elapsed_ff <= req_elapsed_ms;
         brake_ff   <= req_brake_request;
         left_ff    <= req_left_request;
         right_ff   <= req_right_request;
         hazard_ff  <= req_hazard_request;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         brake_duty_ff <= brake_lit_in ? cfg.brake_on_duty : cfg.brake_off_duty;
         left_duty_ff  <= left_lit_in ? cfg.turn_on_duty : cfg.turn_off_duty;
         right_duty_ff <= right_lit_in ? cfg.turn_on_duty : cfg.turn_off_duty;
         left_lit_ff   <= left_lit_in;
         right_lit_ff  <= right_lit_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_brake_duty = brake_duty_ff;
   assign rsp_left_duty  = left_duty_ff;
   assign rsp_right_duty = right_duty_ff;
   assign rsp_left_lit   = left_lit_ff;
   assign rsp_right_lit  = right_lit_ff;

endmodule

// ===== hdl/bstf_csr.sv =====
module bstf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bstf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bstf_pkg::CSR_DATA_W-1:0]   csr_data,
   output bstf_pkg::cfg_type                 cfg
);

   bstf_pkg::cfg_type cfg_ff;
   bstf_pkg::cfg_type cfg_in;

   // Always take a write; narrow duty fields keep the low seven bits
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write into the register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bstf_pkg::CSR_STROBE_FLASHES:     cfg_in.strobe_flashes     = csr_data;
            bstf_pkg::CSR_STROBE_HALF_PERIOD: cfg_in.strobe_half_period = csr_data;
            bstf_pkg::CSR_BRAKE_ON_DUTY:      cfg_in.brake_on_duty      = csr_data[6:0];
            bstf_pkg::CSR_BRAKE_OFF_DUTY:     cfg_in.brake_off_duty     = csr_data[6:0];
            bstf_pkg::CSR_TURN_ON_INTERVAL:   cfg_in.turn_on_interval   = csr_data;
            bstf_pkg::CSR_TURN_OFF_INTERVAL:  cfg_in.turn_off_interval  = csr_data;
            bstf_pkg::CSR_TURN_ON_DUTY:       cfg_in.turn_on_duty       = csr_data[6:0];
            bstf_pkg::CSR_TURN_OFF_DUTY:      cfg_in.turn_off_duty      = csr_data[6:0];
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/bstf_strobe.sv =====
module bstf_strobe (
   input  logic              clock,
   input  logic              reset,
   input  bstf_pkg::cfg_type cfg,
   input  logic              step_en,
   input  logic [7:0]        elapsed_ms,
   input  logic              brake_request,
   output logic              brake_lit_in
);

   localparam int TW = bstf_pkg::STROBE_TIMER_W;

   logic [TW-1:0] timer_ff;
   logic [TW-1:0] timer_in;
   logic [7:0]    count_ff;
   logic [7:0]    count_in;
   logic          lit_ff;
   logic          lit_in;
   logic [TW-1:0] limit;
   logic [TW:0]   sum;
   logic [TW-1:0] sum_sat;

   // Toggle threshold in milliseconds
   assign limit   = TW'(cfg.strobe_half_period) * TW'(bstf_pkg::STROBE_UNIT_MS);
   assign sum     = {1'b0, timer_ff} + (TW + 1)'(elapsed_ms);
   assign sum_sat = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   // Advance the strobe: toggle on timeout, count dark phases, then hold lit
   always_comb begin
      timer_in = timer_ff;
      count_in = count_ff;
      lit_in   = lit_ff;
      if (brake_request) begin
         if (count_ff < cfg.strobe_flashes) begin
            timer_in = sum_sat;
            if (sum_sat >= limit) begin
               timer_in = '0;
               if (!lit_ff) begin
                  count_in = count_ff + 8'd1;
               end
               lit_in = ~lit_ff;
            end
         end else begin
            lit_in = 1'b1;
         end
      end else begin
         // Preload so the next press toggles at once
         lit_in   = 1'b0;
         count_in = '0;
         timer_in = limit;
      end
   end

   assign brake_lit_in = lit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         count_ff <= '0;
         lit_ff   <= 1'b0;
      end else if (step_en) begin
         timer_ff <= timer_in;
         count_ff <= count_in;
         lit_ff   <= lit_in;
      end
   end

endmodule

// ===== hdl/bstf_flasher.sv =====
module bstf_flasher (
   input  logic              clock,
   input  logic              reset,
   input  bstf_pkg::cfg_type cfg,
   input  logic              step_en,
   input  logic [7:0]        elapsed_ms,
   input  logic              any_request,
   output logic              dark_phase_in
);

   localparam int TW = bstf_pkg::FLASH_TIMER_W;

   logic [TW-1:0] timer_ff;
   logic [TW-1:0] timer_in;
   logic          dark_ff;
   logic          dark_in;
   logic [7:0]    interval;
   logic [TW-1:0] limit;
   logic [TW:0]   sum;
   logic [TW-1:0] sum_sat;

   // Length of the current phase in milliseconds
   assign interval = dark_ff ? cfg.turn_off_interval : cfg.turn_on_interval;
   assign limit    = TW'(interval) * TW'(bstf_pkg::FLASH_UNIT_MS);
   assign sum      = {1'b0, timer_ff} + (TW + 1)'(elapsed_ms);
   assign sum_sat  = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   // Advance the phase timer; a zero dark interval forces steady light
   always_comb begin
      timer_in = '0;
      dark_in  = 1'b0;
      if (any_request) begin
         timer_in = sum_sat;
         dark_in  = dark_ff;
         if (sum_sat >= limit) begin
            timer_in = '0;
            dark_in  = ~dark_ff;
         end
         if (cfg.turn_off_interval == 8'd0) begin
            dark_in = 1'b0;
         end
      end
   end

   assign dark_phase_in = dark_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         dark_ff  <= 1'b0;
      end else if (step_en) begin
         timer_ff <= timer_in;
         dark_ff  <= dark_in;
      end
   end

endmodule

// ===== tb/sv/brake_strobe_turn_flasher_unit_tb.sv =====
`timescale 1ns / 1ps

module brake_strobe_turn_flasher_unit_tb;

   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int HOLD_CYCLES      = 60;
   localparam int ITEMS_PER_HALF   = 40;
   localparam int RANDOM_PHASES    = 9;
   localparam int STROBE_TIMER_MAX = (1 << bstf_pkg::STROBE_TIMER_W) - 1;
   localparam int FLASH_TIMER_MAX  = (1 << bstf_pkg::FLASH_TIMER_W) - 1;

   // One tick word on the request side
   typedef struct packed {
      logic [7:0] elapsed_ms;
      logic       brake_request;
      logic       left_request;
      logic       right_request;
      logic       hazard_request;
   } tick_word_type;

   // One lamp word on the result side
   typedef struct packed {
      logic [6:0] brake_duty;
      logic [6:0] left_duty;
      logic [6:0] right_duty;
      logic       left_lit;
      logic       right_lit;
   } lamp_word_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [7:0]                       req_elapsed_ms = '0;
   logic                             req_brake_request = 1'b0;
   logic                             req_left_request = 1'b0;
   logic                             req_right_request = 1'b0;
   logic                             req_hazard_request = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [6:0]                       rsp_brake_duty;
   logic [6:0]                       rsp_left_duty;
   logic [6:0]                       rsp_right_duty;
   logic                             rsp_left_lit;
   logic                             rsp_right_lit;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [bstf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bstf_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   brake_strobe_turn_flasher_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_ms     (req_elapsed_ms),
      .req_brake_request  (req_brake_request),
      .req_left_request   (req_left_request),
      .req_right_request  (req_right_request),
      .req_hazard_request (req_hazard_request),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_brake_duty     (rsp_brake_duty),
      .rsp_left_duty      (rsp_left_duty),
      .rsp_right_duty     (rsp_right_duty),
      .rsp_left_lit       (rsp_left_lit),
      .rsp_right_lit      (rsp_right_lit),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Lamp controller copy: registers and timers
   bstf_pkg::cfg_type lamp_cfg = '0;
   logic [11:0] strobe_timer_q = '0;
   logic [7:0]  strobe_count_q = '0;
   logic        brake_lit_q = 1'b0;
   logic [15:0] flash_timer_q = '0;
   logic        flash_dark_q = 1'b0;

   tick_word_type tick_q[$];
   lamp_word_type lamp_due_q[$];

   int send_idle_pct = 20;
   int recv_idle_pct = 62;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int mismatches = 0;
   int ticks_sent = 0;
   int lamps_checked = 0;
   int input_stall_cycles = 0;
   int settings_loaded = 0;
   int quiet_cycles = 0;

   // Tick pattern generator: brake and turn requests held for runs
   logic       gen_brake = 1'b0;
   logic [2:0] gen_turn = '0;
   int         gen_brake_run = 0;
   int         gen_turn_run = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the lamp controller by one tick and return its lamp word
   function automatic lamp_word_type step_lamps(input tick_word_type t);
      lamp_word_type r;
      int            strobe_limit;
      int            flash_limit;
      int            sum;
      logic          any_turn;
      logic          lit_phase;
      strobe_limit = int'(lamp_cfg.strobe_half_period) * bstf_pkg::STROBE_UNIT_MS;
      if (t.brake_request) begin
         if (strobe_count_q < lamp_cfg.strobe_flashes) begin
            sum = int'(strobe_timer_q) + int'(t.elapsed_ms);
            if (sum > STROBE_TIMER_MAX) sum = STROBE_TIMER_MAX;
            strobe_timer_q = 12'(sum);
            if (sum >= strobe_limit) begin
               strobe_timer_q = '0;
               if (!brake_lit_q) strobe_count_q = strobe_count_q + 8'd1;
               brake_lit_q = ~brake_lit_q;
            end
         end else begin
            brake_lit_q = 1'b1;
         end
      end else begin
         // release clears the count and preloads the timer
         brake_lit_q    = 1'b0;
         strobe_count_q = '0;
         strobe_timer_q = 12'(strobe_limit);
      end

      any_turn = t.left_request | t.right_request | t.hazard_request;
      if (any_turn) begin
         flash_limit = (flash_dark_q ? int'(lamp_cfg.turn_off_interval)
                                     : int'(lamp_cfg.turn_on_interval)) *
                       bstf_pkg::FLASH_UNIT_MS;
         sum = int'(flash_timer_q) + int'(t.elapsed_ms);
         if (sum > FLASH_TIMER_MAX) sum = FLASH_TIMER_MAX;
         flash_timer_q = 16'(sum);
         if (sum >= flash_limit) begin
            flash_timer_q = '0;
            flash_dark_q  = ~flash_dark_q;
         end
         // zero dark interval means steady light
         if (lamp_cfg.turn_off_interval == 8'd0) flash_dark_q = 1'b0;
      end else begin
         flash_timer_q = '0;
         flash_dark_q  = 1'b0;
      end

      lit_phase    = ~flash_dark_q;
      r.left_lit   = lit_phase & (t.left_request | t.hazard_request);
      r.right_lit  = lit_phase & (t.right_request | t.hazard_request);
      r.brake_duty = brake_lit_q ? lamp_cfg.brake_on_duty : lamp_cfg.brake_off_duty;
      r.left_duty  = r.left_lit ? lamp_cfg.turn_on_duty : lamp_cfg.turn_off_duty;
      r.right_duty = r.right_lit ? lamp_cfg.turn_on_duty : lamp_cfg.turn_off_duty;
      return r;
   endfunction

   function automatic logic [6:0] random_duty();
      if ($urandom_range(0, 9) == 0) return 7'($urandom_range(101, 127));
      return 7'($urandom_range(0, 100));
   endfunction

   function automatic bstf_pkg::cfg_type make_settings(input int flashes, input int half_period,
                                                       input int brake_on, input int brake_off,
                                                       input int on_interval,
                                                       input int off_interval,
                                                       input int turn_on, input int turn_off);
      bstf_pkg::cfg_type c;
      c.strobe_flashes     = 8'(flashes);
      c.strobe_half_period = 8'(half_period);
      c.brake_on_duty      = 7'(brake_on);
      c.brake_off_duty     = 7'(brake_off);
      c.turn_on_interval   = 8'(on_interval);
      c.turn_off_interval  = 8'(off_interval);
      c.turn_on_duty       = 7'(turn_on);
      c.turn_off_duty      = 7'(turn_off);
      return c;
   endfunction

   function automatic bstf_pkg::cfg_type random_settings();
      bstf_pkg::cfg_type c;
      c.strobe_flashes     = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
      c.strobe_half_period = 8'($urandom_range(0, 8));
      c.brake_on_duty      = random_duty();
      c.brake_off_duty     = random_duty();
      c.turn_on_interval   = 8'($urandom_range(0, 4));
      c.turn_off_interval  = 8'($urandom_range(0, 4));
      c.turn_on_duty       = random_duty();
      c.turn_off_duty      = random_duty();
      return c;
   endfunction

   // Mostly held request runs with random timing, some noise ticks
   function automatic tick_word_type next_tick();
      tick_word_type w;
      int            pick;
      if (gen_brake_run == 0) begin
         gen_brake     = ~gen_brake;
         gen_brake_run = gen_brake ? $urandom_range(1, 30) : $urandom_range(1, 8);
      end
      gen_brake_run--;
      if (gen_turn_run == 0) begin
         gen_turn     = 3'($urandom_range(0, 7));
         gen_turn_run = $urandom_range(1, 40);
      end
      gen_turn_run--;
      pick = $urandom_range(0, 99);
      if (pick < 8)       w.elapsed_ms = 8'd0;
      else if (pick < 23) w.elapsed_ms = 8'd255;
      else if (pick < 48) w.elapsed_ms = 8'($urandom_range(0, 15));
      else                w.elapsed_ms = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 15) begin
         {w.brake_request, w.left_request, w.right_request, w.hazard_request} =
            4'($urandom_range(0, 15));
      end else begin
         w.brake_request = gen_brake;
         {w.left_request, w.right_request, w.hazard_request} = gen_turn;
      end
      return w;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Write one register and mirror it; leave valid high for a following write
   task automatic csr_put(input logic [bstf_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [bstf_pkg::CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bstf_pkg::CSR_STROBE_FLASHES:     lamp_cfg.strobe_flashes     = data;
         bstf_pkg::CSR_STROBE_HALF_PERIOD: lamp_cfg.strobe_half_period = data;
         bstf_pkg::CSR_BRAKE_ON_DUTY:      lamp_cfg.brake_on_duty      = data[6:0];
         bstf_pkg::CSR_BRAKE_OFF_DUTY:     lamp_cfg.brake_off_duty     = data[6:0];
         bstf_pkg::CSR_TURN_ON_INTERVAL:   lamp_cfg.turn_on_interval   = data;
         bstf_pkg::CSR_TURN_OFF_INTERVAL:  lamp_cfg.turn_off_interval  = data;
         bstf_pkg::CSR_TURN_ON_DUTY:       lamp_cfg.turn_on_duty       = data[6:0];
         bstf_pkg::CSR_TURN_OFF_DUTY:      lamp_cfg.turn_off_duty      = data[6:0];
         default:                          ;
      endcase
   endtask

   // Load a full register set; the unused top bit of duty writes is random
   task automatic load_settings(input bstf_pkg::cfg_type c);
      csr_put(bstf_pkg::CSR_STROBE_FLASHES, c.strobe_flashes);
      csr_put(bstf_pkg::CSR_STROBE_HALF_PERIOD, c.strobe_half_period);
      csr_put(bstf_pkg::CSR_BRAKE_ON_DUTY, {1'($urandom_range(0, 1)), c.brake_on_duty});
      csr_put(bstf_pkg::CSR_BRAKE_OFF_DUTY, {1'($urandom_range(0, 1)), c.brake_off_duty});
      csr_put(bstf_pkg::CSR_TURN_ON_INTERVAL, c.turn_on_interval);
      csr_put(bstf_pkg::CSR_TURN_OFF_INTERVAL, c.turn_off_interval);
      csr_put(bstf_pkg::CSR_TURN_ON_DUTY, {1'($urandom_range(0, 1)), c.turn_on_duty});
      csr_put(bstf_pkg::CSR_TURN_OFF_DUTY, {1'($urandom_range(0, 1)), c.turn_off_duty});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Wait until every tick is sent and every lamp word is back, then settle
   task automatic wait_drained();
      while (tick_q.size() != 0 || lamp_due_q.size() != 0 || req_valid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: hold a stalled word, offer the next one or idle
   always @(posedge clock) begin : tick_driver
      tick_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            w = {req_elapsed_ms, req_brake_request, req_left_request,
                 req_right_request, req_hazard_request};
            lamp_due_q.push_back(step_lamps(w));
            ticks_sent++;
         end
         if (req_valid && req_stall) input_stall_cycles++;
         if (!req_valid || !req_stall) begin
            if (tick_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               w = tick_q.pop_front();
               req_elapsed_ms     <= w.elapsed_ms;
               req_brake_request  <= w.brake_request;
               req_left_request   <= w.left_request;
               req_right_request  <= w.right_request;
               req_hazard_request <= w.hazard_request;
               req_valid          <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each lamp word, then pick the next stall
   always @(posedge clock) begin : lamp_monitor
      lamp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lamp_due_q.size() == 0) begin
               $display("%0t: lamp word with no tick pending", $time);
               mismatches++;
            end else begin
               want = lamp_due_q.pop_front();
               check_field("brake_duty", 8'(want.brake_duty), 8'(rsp_brake_duty));
               check_field("left_duty", 8'(want.left_duty), 8'(rsp_left_duty));
               check_field("right_duty", 8'(want.right_duty), 8'(rsp_right_duty));
               check_field("left_lit", 8'(want.left_lit), 8'(rsp_left_lit));
               check_field("right_lit", 8'(want.right_lit), 8'(rsp_right_lit));
               lamps_checked++;
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: drop the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("brake_strobe_turn_flasher_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      bstf_pkg::cfg_type c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero strobe and zero turn intervals, duty above 100
      load_settings(make_settings(2, 0, 100, 127, 0, 0, 100, 0));
      tick_q.push_back({8'd0,   1'b0, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd255, 1'b1, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd0,   1'b1, 1'b1, 1'b0, 1'b0});
      tick_q.push_back({8'd0,   1'b1, 1'b0, 1'b1, 1'b0});
      tick_q.push_back({8'd255, 1'b1, 1'b0, 1'b0, 1'b1});
      tick_q.push_back({8'd0,   1'b1, 1'b1, 1'b1, 1'b1});
      tick_q.push_back({8'd255, 1'b0, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd1,   1'b1, 1'b0, 1'b0, 1'b0});
      wait_drained();

      // Directed: short strobe, one flash then steady, timed turn phases
      load_settings(make_settings(1, 1, 0, 100, 1, 2, 127, 5));
      tick_q.push_back({8'd5,   1'b1, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd5,   1'b1, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd255, 1'b1, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd100, 1'b0, 1'b1, 1'b0, 1'b0});
      tick_q.push_back({8'd100, 1'b0, 1'b1, 1'b0, 1'b0});
      tick_q.push_back({8'd200, 1'b0, 1'b0, 1'b1, 1'b0});
      tick_q.push_back({8'd200, 1'b0, 1'b0, 1'b0, 1'b1});
      tick_q.push_back({8'd255, 1'b0, 1'b0, 1'b0, 1'b1});
      tick_q.push_back({8'd0,   1'b0, 1'b0, 1'b0, 1'b0});
      tick_q.push_back({8'd255, 1'b1, 1'b1, 1'b1, 1'b1});
      wait_drained();

      // Random phases: idling pattern changes every third phase
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 20;
            recv_idle_pct = 62;
         end else if (ph < 6) begin
            send_idle_pct = 62;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (ph == 1)      c = make_settings(0, 0, 0, 0, 0, 0, 0, 0);
         else if (ph == 3) c = make_settings(255, 255, 127, 127, 255, 255, 127, 127);
         else              c = random_settings();
         load_settings(c);
         repeat (ITEMS_PER_HALF) tick_q.push_back(next_tick());
         // back up the pipe with a long receiver hold while ticks keep coming
         if (ph == 2 || ph == 6) hold_requests++;
         // pause the sender until the pipe is empty
         if (ph == 4) wait_drained();
         repeat (ITEMS_PER_HALF) tick_q.push_back(next_tick());
         wait_drained();
      end

      repeat (8) @(posedge clock);
      $display("Sent %0d ticks and checked %0d lamp words over %0d register settings.",
               ticks_sent, lamps_checked, settings_loaded);
      $display("Input backpressure cycles: %0d, receiver hold-offs: %0d, mismatches: %0d.",
               input_stall_cycles, hold_served, mismatches);
      if (mismatches == 0) begin
         $display("brake_strobe_turn_flasher_unit test passed");
      end else begin
         $display("brake_strobe_turn_flasher_unit test failed");
      end
      $finish;
   end

endmodule
